FILE: src/rgdmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range-gated depth mean filter package
// Shared field widths, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package rgdmf_pkg;

  localparam int unsigned DEPTH_W = 20;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned REG_W   = 20;
  localparam int unsigned IDX_W   = 3;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_HALF      = 3'd2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CEN,
    ST_CLAT,
    ST_WIN,
    ST_WEND,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

FILE: src/rgdmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rgdmf_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 6151
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wa_i,
  input  logic [WIDTH-1:0]         wd_i,
  input  logic [$clog2(DEPTH)-1:0] ra_i,
  output logic [WIDTH-1:0]         rd_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    rd_q <= mem[ra_i];
  end

  assign rd_o = rd_q;

endmodule

FILE: src/rgdmf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgdmf_div #(
  parameter int unsigned NW = 27,
  parameter int unsigned DW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned SW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [SW-1:0] step_q, step_d;
  logic [NW-1:0] num_q, num_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   rem_sh;
  logic          qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem_sh = {rem_q[DW-1:0], num_q[NW-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_d  = {num_q[NW-2:0], qbit};
      step_d = step_q + SW'(1);
      if (step_q == SW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

FILE: src/range_gated_depth_mean_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range-gated depth mean filter
// Window mean of depth neighbours within a threshold, over a sample ring.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// s_axis    in         tuser request kind, tdata depth sample
// m_axis    out        tdata mean, count, row, column; tlast end of frame
// cfg       in         register index and write data
// A request without a result leaves the sequencer idle; one with a result
// runs the window reads from the sample ring (one read per cycle) and the
// bit-serial divider (NW = 27 by default). After reset a clearing pass
// zeroes all 2*MAX_HALF*MAX_WIDTH+2*MAX_HALF+1 ring entries; a write to one of
// the four registers holds off requests until a settle counter runs down.
// A stalled output holds the next result in the sequencer.
// ----------------------------------------------------------------------------
module range_gated_depth_mean_filter
  import rgdmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_HALF   = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,  // depth_in, zero pad
  input  logic             s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // mean_depth, accepted_count, out_row, out_col, pad
  output logic             m_axis_tlast,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0] cfg_data_i
);

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned KW   = $clog2(MAX_HALF + 1);
  localparam int unsigned RING = 2 * MAX_HALF * MAX_WIDTH + 2 * MAX_HALF + 1;
  localparam int unsigned AW   = $clog2(RING);
  localparam int unsigned PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned WIN  = 2 * MAX_HALF + 1;
  localparam int unsigned IW   = $clog2(WIN);
  localparam int unsigned CW   = $clog2(WIN * WIN + 1);
  localparam int unsigned SUMW = DEPTH_W + $clog2(WIN * WIN);
  localparam int unsigned NW   = SUMW + 1;
  localparam int unsigned SW   = ((WW > HW) ? WW : HW) + 2;

  state_e state_q, state_d;

  logic [10:0]        reg_w_q, reg_h_q;
  logic [1:0]         reg_k_q;
  logic [DEPTH_W-1:0] reg_thr_q;
  logic [WW-1:0]      w_eff;
  logic [HW-1:0]      h_eff;
  logic [KW-1:0]      k_eff;
  logic [AW-1:0]      kw_q, lag_q;
  logic [PW-1:0]      total_q;
  logic [1:0]         settle_q;
  logic               cfg_hit;

  logic [HW-1:0] in_row_q, in_row_d, orow_q, orow_d;
  logic [WW-1:0] in_col_q, in_col_d, ocol_q, ocol_d;
  logic [PW-1:0] idx_q, idx_d, outp_q, outp_d;
  logic [AW-1:0] wa_q, wa_d, oa_q, oa_d;
  logic          fc_q, fc_d;
  logic          in_acc, emit;

  logic [HW-1:0] p_row_q, p_row_d;
  logic [WW-1:0] p_col_q, p_col_d;
  logic          p_last_q, p_last_d;
  logic [AW-1:0] p_addr_q, p_addr_d;

  logic               mem_we;
  logic [AW-1:0]      mem_wa, mem_ra, clr_q;
  logic [DEPTH_W-1:0] mem_wd, mem_rd;

  logic [IW-1:0]      dr_q, dr_d, dc_q, dc_d;
  logic [AW-1:0]      ra_q, ra_d, rowa_q, rowa_d;
  logic signed [SW-1:0] rr_q, rr_d, cc_q, cc_d;
  logic               pv_q, pv_d, inframe;
  logic [DEPTH_W-1:0] center_q, diff;
  logic [SUMW-1:0]    sum_q;
  logic [CW-1:0]      cnt_q;
  logic [AW:0]        start_sum, row_next, col_next;
  logic [IW-1:0]      last_i;

  logic          div_start, div_done;
  logic [NW-1:0] div_quot;

  logic               ov_q;
  logic [DEPTH_W-1:0] o_mean_q;
  logic [CNT_W-1:0]   o_cnt_q;
  logic [POS_W-1:0]   o_row_q, o_col_q;
  logic               o_last_q, o_load;

  // Effective register values.
  always_comb begin
    if (reg_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(reg_w_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(reg_w_q);
    end
    if (reg_h_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(reg_h_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(reg_h_q);
    end
    k_eff = (32'(reg_k_q) > MAX_HALF) ? KW'(MAX_HALF) : KW'(reg_k_q);
  end

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT ||
                               cfg_idx_i == REG_HALF || cfg_idx_i == REG_THRESHOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_w_q   <= 11'd512;
      reg_h_q   <= 11'd512;
      reg_k_q   <= 2'd1;
      reg_thr_q <= 20'd31;
      settle_q  <= 2'd3;
      kw_q      <= '0;
      lag_q     <= '0;
      total_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH:     reg_w_q   <= cfg_data_i[10:0];
          REG_HEIGHT:    reg_h_q   <= cfg_data_i[10:0];
          REG_HALF:      reg_k_q   <= cfg_data_i[1:0];
          REG_THRESHOLD: reg_thr_q <= cfg_data_i[DEPTH_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        settle_q <= 2'd3;
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
      kw_q    <= AW'(32'(k_eff) * 32'(w_eff));
      lag_q   <= kw_q + AW'(k_eff);
      total_q <= PW'(32'(w_eff) * 32'(h_eff));
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE) && (settle_q == 2'd0);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Request bookkeeping and ring writes.
  always_comb begin
    in_row_d = in_row_q;
    in_col_d = in_col_q;
    idx_d    = idx_q;
    wa_d     = wa_q;
    outp_d   = outp_q;
    orow_d   = orow_q;
    ocol_d   = ocol_q;
    oa_d     = oa_q;
    fc_d     = fc_q;
    p_row_d  = p_row_q;
    p_col_d  = p_col_q;
    p_last_d = p_last_q;
    p_addr_d = p_addr_q;
    emit     = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = wa_q;
    mem_wd   = s_axis_tdata[DEPTH_W-1:0];
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end
    if (cfg_hit) begin
      in_row_d = '0;
      in_col_d = '0;
      idx_d    = '0;
      wa_d     = '0;
      outp_d   = '0;
      orow_d   = '0;
      ocol_d   = '0;
      oa_d     = '0;
      fc_d     = 1'b0;
    end else if (in_acc) begin
      if (s_axis_tuser == REQ_PIXEL) begin
        if (fc_d) begin
          in_row_d = '0;
          in_col_d = '0;
          idx_d    = '0;
          wa_d     = '0;
          outp_d   = '0;
          orow_d   = '0;
          ocol_d   = '0;
          oa_d     = '0;
          fc_d     = 1'b0;
        end
        mem_we = 1'b1;
        mem_wa = wa_d;
        emit   = (idx_d >= PW'(lag_q)) && (outp_d < total_q);
        if ({1'b0, in_col_d} + (WW + 1)'(1) >= {1'b0, w_eff}) begin
          in_col_d = '0;
          in_row_d = in_row_d + HW'(1);
        end else begin
          in_col_d = in_col_d + WW'(1);
        end
        if ({1'b0, idx_d} + (PW + 1)'(1) >= {1'b0, total_q}) begin
          fc_d     = 1'b1;
          in_row_d = '0;
          in_col_d = '0;
          idx_d    = '0;
          wa_d     = '0;
        end else begin
          idx_d = idx_d + PW'(1);
          wa_d  = (wa_d == AW'(RING - 1)) ? '0 : wa_d + AW'(1);
        end
      end else begin
        emit = fc_d && (outp_d < total_q);
      end
      if (emit) begin
        p_row_d  = orow_d;
        p_col_d  = ocol_d;
        p_addr_d = oa_d;
        p_last_d = ({1'b0, outp_d} + (PW + 1)'(1) == {1'b0, total_q});
        outp_d   = outp_d + PW'(1);
        oa_d     = (oa_d == AW'(RING - 1)) ? '0 : oa_d + AW'(1);
        if ({1'b0, ocol_d} + (WW + 1)'(1) >= {1'b0, w_eff}) begin
          ocol_d = '0;
          orow_d = orow_d + HW'(1);
        end else begin
          ocol_d = ocol_d + WW'(1);
        end
      end
      if (fc_d && (outp_d >= total_q)) begin
        in_row_d = '0;
        in_col_d = '0;
        idx_d    = '0;
        wa_d     = '0;
        outp_d   = '0;
        orow_d   = '0;
        ocol_d   = '0;
        oa_d     = '0;
        fc_d     = 1'b0;
      end
    end
  end

  // Window sequencer.
  assign last_i    = IW'(2 * 32'(k_eff));
  assign start_sum = (p_addr_q >= lag_q) ? {1'b0, p_addr_q - lag_q}
                                         : {1'b0, p_addr_q} + (AW + 1)'(RING) - {1'b0, lag_q};
  assign row_next  = {1'b0, rowa_q} + (AW + 1)'(w_eff);
  assign col_next  = {1'b0, ra_q} + (AW + 1)'(1);
  assign inframe   = (rr_q >= 0) && (rr_q < $signed(SW'(h_eff))) &&
                     (cc_q >= 0) && (cc_q < $signed(SW'(w_eff)));

  always_comb begin
    state_d   = state_q;
    dr_d      = dr_q;
    dc_d      = dc_q;
    ra_d      = ra_q;
    rowa_d    = rowa_q;
    rr_d      = rr_q;
    cc_d      = cc_q;
    pv_d      = 1'b0;
    mem_ra    = ra_q;
    div_start = 1'b0;
    o_load    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(RING - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && emit) begin
          state_d = ST_CEN;
        end
      end
      ST_CEN: begin
        mem_ra  = p_addr_q;
        state_d = ST_CLAT;
      end
      ST_CLAT: begin
        ra_d    = start_sum[AW-1:0];
        rowa_d  = start_sum[AW-1:0];
        rr_d    = $signed(SW'(p_row_q)) - $signed(SW'(k_eff));
        cc_d    = $signed(SW'(p_col_q)) - $signed(SW'(k_eff));
        dr_d    = '0;
        dc_d    = '0;
        state_d = ST_WIN;
      end
      ST_WIN: begin
        mem_ra = ra_q;
        pv_d   = inframe;
        if (dc_q == last_i) begin
          if (dr_q == last_i) begin
            state_d = ST_WEND;
          end else begin
            dr_d   = dr_q + IW'(1);
            dc_d   = '0;
            rowa_d = (row_next >= (AW + 1)'(RING)) ? AW'(row_next - (AW + 1)'(RING))
                                                  : row_next[AW-1:0];
            ra_d   = rowa_d;
            rr_d   = rr_q + SW'(1);
            cc_d   = $signed(SW'(p_col_q)) - $signed(SW'(k_eff));
          end
        end else begin
          dc_d = dc_q + IW'(1);
          ra_d = (col_next >= (AW + 1)'(RING)) ? '0 : col_next[AW-1:0];
          cc_d = cc_q + SW'(1);
        end
      end
      ST_WEND: begin
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_q || m_axis_tready) begin
          o_load  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign diff = (mem_rd > center_q) ? (mem_rd - center_q) : (center_q - mem_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      in_row_q <= '0;
      in_col_q <= '0;
      idx_q    <= '0;
      wa_q     <= '0;
      outp_q   <= '0;
      orow_q   <= '0;
      ocol_q   <= '0;
      oa_q     <= '0;
      fc_q     <= 1'b0;
      pv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      in_row_q <= in_row_d;
      in_col_q <= in_col_d;
      idx_q    <= idx_d;
      wa_q     <= wa_d;
      outp_q   <= outp_d;
      orow_q   <= orow_d;
      ocol_q   <= ocol_d;
      oa_q     <= oa_d;
      fc_q     <= fc_d;
      pv_q     <= pv_d;
      if (o_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_row_q  <= p_row_d;
    p_col_q  <= p_col_d;
    p_last_q <= p_last_d;
    p_addr_q <= p_addr_d;
    dr_q     <= dr_d;
    dc_q     <= dc_d;
    ra_q     <= ra_d;
    rowa_q   <= rowa_d;
    rr_q     <= rr_d;
    cc_q     <= cc_d;
    if (state_q == ST_CLAT) begin
      center_q <= mem_rd;
      sum_q    <= '0;
      cnt_q    <= '0;
    end else if (pv_q && (diff < reg_thr_q)) begin
      sum_q <= sum_q + SUMW'(mem_rd);
      cnt_q <= cnt_q + CW'(1);
    end
    if (o_load) begin
      o_mean_q <= (cnt_q == '0) ? '0 : div_quot[DEPTH_W-1:0];
      o_cnt_q  <= CNT_W'(cnt_q);
      o_row_q  <= POS_W'(p_row_q);
      o_col_q  <= POS_W'(p_col_q);
      o_last_q <= p_last_q;
    end
  end

  rgdmf_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (RING)
  ) u_ring (
    .clk_i (clk_i),
    .we_i  (mem_we),
    .wa_i  (mem_wa),
    .wd_i  (mem_wd),
    .ra_i  (mem_ra),
    .rd_o  (mem_rd)
  );

  rgdmf_div #(
    .NW (NW),
    .DW (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NW'(sum_q) + NW'(cnt_q >> 1)),
    .den_i   (cnt_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, o_col_q, o_row_q, o_cnt_q, o_mean_q};
  assign m_axis_tlast  = o_last_q;

  a_ready_after_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q != ST_CLEAR) && (settle_q == 2'd0))
    else $error("request taken during clearing or settling");

  a_ring_read_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WIN) |-> (ra_q < AW'(RING)) && (rowa_q < AW'(RING)))
    else $error("window address outside the ring");

  a_result_from_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(state_q == ST_OUT))
    else $error("result shown without a finished window");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DSTART) |-> (32'(cnt_q) <= (2 * 32'(k_eff) + 1) * (2 * 32'(k_eff) + 1)))
    else $error("count exceeds the window size");

endmodule
